[rtl/mgb_pkg.sv]
// Shared types, codes and helper functions of the maze carver.
package mgb_pkg;

  // Width of the microcode step counter
  localparam int STEP_W = 5;

  // Reset value of both size registers
  localparam logic [5:0] GRID_RESET = 6'd32;

  // Input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Configuration register indexes
  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

  // Result event kinds
  localparam logic [2:0] EV_CARVED    = 3'd0;
  localparam logic [2:0] EV_BACKTRACK = 3'd1;
  localparam logic [2:0] EV_FINISHED  = 3'd2;
  localparam logic [2:0] EV_READ      = 3'd3;
  localparam logic [2:0] EV_STARTED   = 3'd4;

  // Carving directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Cell word: bits 3..0 open walls, bit 4 visited
  localparam logic [4:0] CELL_VISITED = 5'b1_0000;

  // Cell memory address select
  localparam logic [3:0] ADR_CUR    = 4'd0;
  localparam logic [3:0] ADR_LEFT   = 4'd1;
  localparam logic [3:0] ADR_RIGHT  = 4'd2;
  localparam logic [3:0] ADR_UP     = 4'd3;
  localparam logic [3:0] ADR_DOWN   = 4'd4;
  localparam logic [3:0] ADR_NEXT   = 4'd5;
  localparam logic [3:0] ADR_CLEAR  = 4'd6;
  localparam logic [3:0] ADR_REQ    = 4'd7;
  localparam logic [3:0] ADR_ORIGIN = 4'd8;

  // Cell memory write data select
  localparam logic [2:0] WD_ZERO    = 3'd0;
  localparam logic [2:0] WD_ORIGIN  = 3'd1;
  localparam logic [2:0] WD_CUR     = 3'd2;
  localparam logic [2:0] WD_CURWALL = 3'd3;
  localparam logic [2:0] WD_NEXT    = 3'd4;

  // Datapath register captures
  localparam logic [2:0] CAP_NONE  = 3'd0;
  localparam logic [2:0] CAP_LOAD  = 3'd1;
  localparam logic [2:0] CAP_CUR   = 3'd2;
  localparam logic [2:0] CAP_LEFT  = 3'd3;
  localparam logic [2:0] CAP_RIGHT = 3'd4;
  localparam logic [2:0] CAP_UP    = 3'd5;
  localparam logic [2:0] CAP_DOWN  = 3'd6;
  localparam logic [2:0] CAP_DIR   = 3'd7;

  // Stack operations
  localparam logic [2:0] STK_NONE      = 3'd0;
  localparam logic [2:0] STK_POP       = 3'd1;
  localparam logic [2:0] STK_PUSH_CUR  = 3'd2;
  localparam logic [2:0] STK_PUSH_NEXT = 3'd3;
  localparam logic [2:0] STK_INIT      = 3'd4;

  // Sequencer jumps
  localparam logic [2:0] JMP_NEXT  = 3'd0;
  localparam logic [2:0] JMP_DONE  = 3'd1;
  localparam logic [2:0] JMP_EMPTY = 3'd2;
  localparam logic [2:0] JMP_NONE  = 3'd3;
  localparam logic [2:0] JMP_CLEAR = 3'd4;

  // One microcode control word
  typedef struct packed {
    logic              mem_rd;
    logic              mem_wr;
    logic [3:0]        addr_sel;
    logic [2:0]        wd_sel;
    logic [2:0]        cap;
    logic [2:0]        stk;
    logic              emit;
    logic [2:0]        kind;
    logic [2:0]        jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic stack_empty;
    logic no_cand;
    logic clear_last;
    logic emit_ok;
  } stat_t;

  // Remainder of a 15-bit value by three: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3_15(input logic [14:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'(v[14]);
    for (int i = 0; i < 7; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // Direction of the k-th candidate in left, right, up, down order
  function automatic logic [1:0] pick_dir(input logic [3:0] mask, input logic [1:0] k);
    logic [1:0] seen;
    logic [1:0] dir;
    seen = '0;
    dir  = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == k) begin
          dir = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
    return dir;
  endfunction

  // Wall bit facing a direction
  function automatic logic [3:0] wall_bit(input logic [1:0] dir);
    return 4'b0001 << dir;
  endfunction

endpackage

[rtl/mgb_sequencer.sv]
// Microcode step counter and control store of the maze carver.
module mgb_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [1:0]      cmd_i,
  input  mgb_pkg::stat_t  stat_i,
  output logic            ready_o,
  output mgb_pkg::ctrl_t  ctrl_o
);
  import mgb_pkg::*;

  // Program addresses
  localparam logic [STEP_W-1:0] P_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] P_RCLR = 5'd1;
  localparam logic [STEP_W-1:0] P_SCLR = 5'd2;
  localparam logic [STEP_W-1:0] P_SORG = 5'd3;
  localparam logic [STEP_W-1:0] P_RD0  = 5'd4;
  localparam logic [STEP_W-1:0] P_RD1  = 5'd5;
  localparam logic [STEP_W-1:0] P_ST0  = 5'd6;
  localparam logic [STEP_W-1:0] P_ST1  = 5'd7;
  localparam logic [STEP_W-1:0] P_ST2  = 5'd8;
  localparam logic [STEP_W-1:0] P_ST3  = 5'd9;
  localparam logic [STEP_W-1:0] P_ST4  = 5'd10;
  localparam logic [STEP_W-1:0] P_ST5  = 5'd11;
  localparam logic [STEP_W-1:0] P_ST6  = 5'd12;
  localparam logic [STEP_W-1:0] P_ST7  = 5'd13;
  localparam logic [STEP_W-1:0] P_ST8  = 5'd14;
  localparam logic [STEP_W-1:0] P_CV0  = 5'd15;
  localparam logic [STEP_W-1:0] P_CV1  = 5'd16;
  localparam logic [STEP_W-1:0] P_CV2  = 5'd17;
  localparam logic [STEP_W-1:0] P_BACK = 5'd18;
  localparam logic [STEP_W-1:0] P_FIN  = 5'd19;

  logic [STEP_W-1:0] pc_q, pc_d;

  // Control store
  always_comb begin
    ctrl_o = '0;
    unique case (pc_q)
      P_IDLE: begin
        ctrl_o.jmp = JMP_NEXT;
      end
      P_RCLR: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_CLEAR;
        ctrl_o.wd_sel   = WD_ZERO;
        ctrl_o.jmp      = JMP_CLEAR;
        ctrl_o.target   = P_IDLE;
      end
      P_SCLR: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_CLEAR;
        ctrl_o.wd_sel   = WD_ZERO;
        ctrl_o.jmp      = JMP_CLEAR;
        ctrl_o.target   = P_SORG;
      end
      P_SORG: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_ORIGIN;
        ctrl_o.wd_sel   = WD_ORIGIN;
        ctrl_o.stk      = STK_INIT;
        ctrl_o.emit     = 1'b1;
        ctrl_o.kind     = EV_STARTED;
        ctrl_o.jmp      = JMP_DONE;
      end
      P_RD0: begin
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_REQ;
      end
      P_RD1: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.kind = EV_READ;
        ctrl_o.jmp  = JMP_DONE;
      end
      P_ST0: begin
        ctrl_o.stk    = STK_POP;
        ctrl_o.jmp    = JMP_EMPTY;
        ctrl_o.target = P_FIN;
      end
      P_ST1: begin
        ctrl_o.cap = CAP_LOAD;
      end
      P_ST2: begin
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_CUR;
      end
      P_ST3: begin
        ctrl_o.cap      = CAP_CUR;
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_LEFT;
      end
      P_ST4: begin
        ctrl_o.cap      = CAP_LEFT;
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_RIGHT;
      end
      P_ST5: begin
        ctrl_o.cap      = CAP_RIGHT;
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_UP;
      end
      P_ST6: begin
        ctrl_o.cap      = CAP_UP;
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADR_DOWN;
      end
      P_ST7: begin
        ctrl_o.cap = CAP_DOWN;
      end
      P_ST8: begin
        ctrl_o.cap    = CAP_DIR;
        ctrl_o.jmp    = JMP_NONE;
        ctrl_o.target = P_BACK;
      end
      P_CV0: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_CUR;
        ctrl_o.wd_sel   = WD_CURWALL;
        ctrl_o.stk      = STK_PUSH_CUR;
      end
      P_CV1: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_NEXT;
        ctrl_o.wd_sel   = WD_NEXT;
        ctrl_o.stk      = STK_PUSH_NEXT;
      end
      P_CV2: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.kind = EV_CARVED;
        ctrl_o.jmp  = JMP_DONE;
      end
      P_BACK: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADR_CUR;
        ctrl_o.wd_sel   = WD_CUR;
        ctrl_o.emit     = 1'b1;
        ctrl_o.kind     = EV_BACKTRACK;
        ctrl_o.jmp      = JMP_DONE;
      end
      P_FIN: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.kind = EV_FINISHED;
        ctrl_o.jmp  = JMP_DONE;
      end
      default: begin
        ctrl_o.jmp = JMP_DONE;
      end
    endcase
  end

  assign ready_o = (pc_q == P_IDLE);

  // Dispatch a command, hold on a blocked result, else follow the jump
  always_comb begin
    pc_d = pc_q;
    if (pc_q == P_IDLE) begin
      if (accept_i) begin
        unique case (cmd_i)
          CMD_START: pc_d = P_SCLR;
          CMD_STEP:  pc_d = P_ST0;
          CMD_READ:  pc_d = P_RD0;
          default:   pc_d = P_IDLE;
        endcase
      end
    end else if (ctrl_o.emit && !stat_i.emit_ok) begin
      pc_d = pc_q;
    end else begin
      unique case (ctrl_o.jmp)
        JMP_NEXT:  pc_d = pc_q + 1'b1;
        JMP_EMPTY: pc_d = stat_i.stack_empty ? ctrl_o.target : pc_q + 1'b1;
        JMP_NONE:  pc_d = stat_i.no_cand ? ctrl_o.target : pc_q + 1'b1;
        JMP_CLEAR: pc_d = stat_i.clear_last ? ctrl_o.target : pc_q;
        default:   pc_d = P_IDLE;
      endcase
    end
  end

  // Step counter; reset enters the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_RCLR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[rtl/maze_generation_backtracker.sv]
// Depth-first maze carver: cell memory, trace stack and microcoded control.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_ready_o | command, random_value, cell_row/col
//  out     | output    | out_valid_o/out_ready_i | event_kind, cur_row/col, direction,
//          |           |                         | open_walls, cell_visited
//  cfg     | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// The single-port cell memory sets the pace: a step reads the popped cell and its four
// neighbours one per cycle, then writes two cells on a carve or one on a backtrack.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS cells runs with in_ready_o low.
// A start runs the same pass before it reports. A finished result waits in the output
// register; the next item is taken meanwhile and stalls only at its own result step.
module maze_generation_backtracker #(
  parameter int MAX_COLS    = 32,
  parameter int MAX_ROWS    = 32,
  parameter int STACK_DEPTH = 1025
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [14:0] random_value_i,
  input  logic [4:0]  cell_row_i,
  input  logic [4:0]  cell_col_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [4:0]  cur_row_o,
  output logic [4:0]  cur_col_o,
  output logic [1:0]  direction_o,
  output logic [3:0]  open_walls_o,
  output logic        cell_visited_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import mgb_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int EntW  = RowW + ColW;
  localparam int SIW   = $clog2(STACK_DEPTH);
  localparam int SCW   = $clog2(STACK_DEPTH + 1);

  localparam logic [AW-1:0]  RowStep   = AW'(MAX_COLS);
  localparam logic [AW-1:0]  LastCell  = AW'(CELLS - 1);
  localparam logic [SCW-1:0] StackFull = SCW'(STACK_DEPTH);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_accept;
  logic  emit_ok;
  logic  emit_fire;

  // Configuration registers
  logic [5:0] grid_w_q, grid_h_q;

  // Latched request
  logic [4:0]    req_row_q, req_col_q;
  logic [AW-1:0] req_addr_q;
  logic          req_ok_q;
  logic [1:0]    rnd_lo_q, rnd_m3_q;

  // Current cell and neighbours
  logic [RowW-1:0] cur_row_q;
  logic [ColW-1:0] cur_col_q;
  logic [AW-1:0]   cur_addr_q;
  logic [4:0]      cur_cell_q;
  logic [4:0]      nb_cell_q [4];
  logic [1:0]      dir_q;
  logic [AW-1:0]   nb_addr [4];
  logic [3:0]      nb_ok;
  logic [3:0]      cand_mask;
  logic [2:0]      cand_cnt;
  logic [1:0]      cand_k;
  logic [WW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic [RowW-1:0] nxt_row;
  logic [ColW-1:0] nxt_col;

  // Cell memory
  logic [4:0]    cell_mem [CELLS];
  logic [4:0]    cell_rdata_q;
  logic [AW-1:0] cell_addr;
  logic [4:0]    cell_wdata;
  logic [AW-1:0] clr_q;
  logic          clear_last;

  // Trace stack
  logic [EntW-1:0] stk_mem [STACK_DEPTH];
  logic [EntW-1:0] stk_rdata_q;
  logic [EntW-1:0] stk_wdata;
  logic [SIW-1:0]  stk_addr;
  logic            stk_rd, stk_wr;
  logic [SCW-1:0]  stk_cnt_q, stk_cnt_d, stk_top;
  logic            stk_empty, stk_room;

  // Output register
  logic       out_valid_q;
  logic [2:0] out_kind_q;
  logic [4:0] out_row_q, out_col_q;
  logic [1:0] out_dir_q;
  logic [3:0] out_walls_q;
  logic       out_vis_q;

  mgb_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .cmd_i    (command_i),
    .stat_i   (stat),
    .ready_o  (in_ready_o),
    .ctrl_o   (ctrl)
  );

  assign in_accept = in_valid_i && in_ready_o;
  assign emit_ok   = !out_valid_q || out_ready_i;
  assign emit_fire = ctrl.emit && emit_ok;

  assign stat.stack_empty = stk_empty;
  assign stat.no_cand     = (cand_mask == 4'b0000);
  assign stat.clear_last  = clear_last;
  assign stat.emit_ok     = emit_ok;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, large values saturate
  always_comb begin
    if (grid_w_q == 6'd0) begin
      eff_w = WW'(1);
    end else if (32'(grid_w_q) > MAX_COLS) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(grid_w_q);
    end
    if (grid_h_q == 6'd0) begin
      eff_h = HW'(1);
    end else if (32'(grid_h_q) > MAX_ROWS) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(grid_h_q);
    end
  end

  // Neighbour bounds and addresses
  always_comb begin
    nb_ok[DIR_LEFT]  = (cur_col_q != '0) && (32'(cur_col_q) - 1 < 32'(eff_w))
                       && (32'(cur_row_q) < 32'(eff_h));
    nb_ok[DIR_RIGHT] = (32'(cur_col_q) + 1 < 32'(eff_w)) && (32'(cur_row_q) < 32'(eff_h));
    nb_ok[DIR_UP]    = (cur_row_q != '0) && (32'(cur_row_q) - 1 < 32'(eff_h))
                       && (32'(cur_col_q) < 32'(eff_w));
    nb_ok[DIR_DOWN]  = (32'(cur_row_q) + 1 < 32'(eff_h)) && (32'(cur_col_q) < 32'(eff_w));
    nb_addr[DIR_LEFT]  = cur_addr_q - AW'(1);
    nb_addr[DIR_RIGHT] = cur_addr_q + AW'(1);
    nb_addr[DIR_UP]    = cur_addr_q - RowStep;
    nb_addr[DIR_DOWN]  = cur_addr_q + RowStep;
  end

  // Candidates and the chosen entry
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand_mask[i] = nb_ok[i] && !nb_cell_q[i][4];
    end
    cand_cnt = 3'($countones(cand_mask));
    unique case (cand_cnt)
      3'd2:    cand_k = {1'b0, rnd_lo_q[0]};
      3'd3:    cand_k = rnd_m3_q;
      3'd4:    cand_k = rnd_lo_q;
      default: cand_k = 2'd0;
    endcase
  end

  // Coordinates of the carved neighbour
  always_comb begin
    nxt_row = cur_row_q;
    nxt_col = cur_col_q;
    unique case (dir_q)
      DIR_LEFT:  nxt_col = cur_col_q - ColW'(1);
      DIR_RIGHT: nxt_col = cur_col_q + ColW'(1);
      DIR_UP:    nxt_row = cur_row_q - RowW'(1);
      default:   nxt_row = cur_row_q + RowW'(1);
    endcase
  end

  // Cell memory address and write data
  always_comb begin
    unique case (ctrl.addr_sel)
      ADR_LEFT:   cell_addr = nb_ok[DIR_LEFT]  ? nb_addr[DIR_LEFT]  : cur_addr_q;
      ADR_RIGHT:  cell_addr = nb_ok[DIR_RIGHT] ? nb_addr[DIR_RIGHT] : cur_addr_q;
      ADR_UP:     cell_addr = nb_ok[DIR_UP]    ? nb_addr[DIR_UP]    : cur_addr_q;
      ADR_DOWN:   cell_addr = nb_ok[DIR_DOWN]  ? nb_addr[DIR_DOWN]  : cur_addr_q;
      ADR_NEXT:   cell_addr = nb_addr[dir_q];
      ADR_CLEAR:  cell_addr = clr_q;
      ADR_REQ:    cell_addr = req_addr_q;
      ADR_ORIGIN: cell_addr = '0;
      default:    cell_addr = cur_addr_q;
    endcase
    unique case (ctrl.wd_sel)
      WD_ORIGIN:  cell_wdata = CELL_VISITED;
      WD_CUR:     cell_wdata = cur_cell_q;
      WD_CURWALL: cell_wdata = cur_cell_q | {1'b0, wall_bit(dir_q)};
      WD_NEXT:    cell_wdata = nb_cell_q[dir_q] | {1'b0, wall_bit(dir_q ^ 2'd1)};
      default:    cell_wdata = '0;
    endcase
  end

  // Cell memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl.mem_wr) begin
      cell_mem[cell_addr] <= cell_wdata;
    end
    if (ctrl.mem_rd) begin
      cell_rdata_q <= cell_mem[cell_addr];
    end
  end

  // Clearing address: advance on each clearing write, wrap at the last cell
  assign clear_last = (clr_q == LastCell);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl.mem_wr && ctrl.addr_sel == ADR_CLEAR) begin
      clr_q <= clear_last ? '0 : clr_q + AW'(1);
    end
  end

  // Stack control: pop reads the top, pushes past a full stack are dropped
  assign stk_empty = (stk_cnt_q == '0);
  assign stk_room  = (stk_cnt_q < StackFull);
  assign stk_top   = stk_cnt_q - SCW'(1);

  always_comb begin
    stk_rd    = 1'b0;
    stk_wr    = 1'b0;
    stk_addr  = stk_cnt_q[SIW-1:0];
    stk_wdata = {cur_row_q, cur_col_q};
    stk_cnt_d = stk_cnt_q;
    unique case (ctrl.stk)
      STK_POP: begin
        stk_rd   = !stk_empty;
        stk_addr = stk_top[SIW-1:0];
        if (!stk_empty) begin
          stk_cnt_d = stk_top;
        end
      end
      STK_PUSH_CUR: begin
        stk_wr = stk_room;
        if (stk_room) begin
          stk_cnt_d = stk_cnt_q + SCW'(1);
        end
      end
      STK_PUSH_NEXT: begin
        stk_wr    = stk_room;
        stk_wdata = {nxt_row, nxt_col};
        if (stk_room) begin
          stk_cnt_d = stk_cnt_q + SCW'(1);
        end
      end
      STK_INIT: begin
        stk_wr    = 1'b1;
        stk_addr  = '0;
        stk_wdata = '0;
        stk_cnt_d = SCW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_wr) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    if (stk_rd) begin
      stk_rdata_q <= stk_mem[stk_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_cnt_q <= '0;
    end else begin
      stk_cnt_q <= stk_cnt_d;
    end
  end

  // Latch the request on transfer
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_row_q  <= cell_row_i;
      req_col_q  <= cell_col_i;
      req_ok_q   <= (32'(cell_row_i) < MAX_ROWS) && (32'(cell_col_i) < MAX_COLS);
      req_addr_q <= ((32'(cell_row_i) < MAX_ROWS) && (32'(cell_col_i) < MAX_COLS))
                    ? AW'(32'(cell_row_i) * MAX_COLS + 32'(cell_col_i)) : '0;
      rnd_lo_q   <= random_value_i[1:0];
      rnd_m3_q   <= mod3_15(random_value_i);
    end
  end

  // Capture popped coordinates, cell words and the chosen direction
  always_ff @(posedge clk_i) begin
    unique case (ctrl.cap)
      CAP_LOAD: begin
        cur_row_q  <= stk_rdata_q[EntW-1 -: RowW];
        cur_col_q  <= stk_rdata_q[ColW-1:0];
        cur_addr_q <= AW'(32'(stk_rdata_q[EntW-1 -: RowW]) * MAX_COLS
                          + 32'(stk_rdata_q[ColW-1:0]));
      end
      CAP_CUR:   cur_cell_q <= cell_rdata_q | CELL_VISITED;
      CAP_LEFT:  nb_cell_q[DIR_LEFT]  <= cell_rdata_q;
      CAP_RIGHT: nb_cell_q[DIR_RIGHT] <= cell_rdata_q;
      CAP_UP:    nb_cell_q[DIR_UP]    <= cell_rdata_q;
      CAP_DOWN:  nb_cell_q[DIR_DOWN]  <= cell_rdata_q;
      CAP_DIR:   dir_q <= pick_dir(cand_mask, cand_k);
      default: ;
    endcase
  end

  // Output register: fill on a result, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_kind_q <= ctrl.kind;
      unique case (ctrl.kind)
        EV_STARTED: begin
          out_row_q   <= '0;
          out_col_q   <= '0;
          out_dir_q   <= '0;
          out_walls_q <= '0;
          out_vis_q   <= 1'b1;
        end
        EV_READ: begin
          out_row_q   <= req_row_q;
          out_col_q   <= req_col_q;
          out_dir_q   <= '0;
          out_walls_q <= req_ok_q ? cell_rdata_q[3:0] : 4'b0000;
          out_vis_q   <= req_ok_q && cell_rdata_q[4];
        end
        EV_BACKTRACK: begin
          out_row_q   <= 5'(cur_row_q);
          out_col_q   <= 5'(cur_col_q);
          out_dir_q   <= '0;
          out_walls_q <= cur_cell_q[3:0];
          out_vis_q   <= cur_cell_q[4];
        end
        EV_CARVED: begin
          out_row_q   <= 5'(cur_row_q);
          out_col_q   <= 5'(cur_col_q);
          out_dir_q   <= dir_q;
          out_walls_q <= cur_cell_q[3:0] | wall_bit(dir_q);
          out_vis_q   <= cur_cell_q[4];
        end
        default: begin
          out_row_q   <= '0;
          out_col_q   <= '0;
          out_dir_q   <= '0;
          out_walls_q <= '0;
          out_vis_q   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign cur_row_o      = out_row_q;
  assign cur_col_o      = out_col_q;
  assign direction_o    = out_dir_q;
  assign open_walls_o   = out_walls_q;
  assign cell_visited_o = out_vis_q;

  // Stack count never passes the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) stk_cnt_q <= StackFull)
    else $error("trace stack count beyond depth");

  // A real command leaves the idle step at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && command_i != CMD_NOP |=> !in_ready_o)
    else $error("command taken but sequencer stayed idle");

  // A carved direction always points at an in-bounds neighbour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && ctrl.kind == EV_CARVED |-> nb_ok[dir_q])
    else $error("carve toward an out-of-bounds neighbour");

  // The clearing address is back at zero whenever the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> clr_q == '0)
    else $error("clearing pass left unfinished");

endmodule
